// File: design/efd_pkg.sv
// Shared types and constants for the escape-framed deframer with XOR check.
package efd_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] count_type;
   typedef logic [1:0]  csr_index_type;
   typedef logic [15:0] csr_data_type;

   typedef enum logic [2:0] {
      ST_PAYLOAD  = 3'd0,
      ST_GOOD     = 3'd1,
      ST_BADSUM   = 3'd2,
      ST_BADESC   = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_MARKER = 2'd0,
      CSR_ESCAPE = 2'd1,
      CSR_LIMIT  = 2'd2
   } csr_reg_type;

   localparam byte_type  MARKER_RESET = 8'h7E;
   localparam byte_type  ESCAPE_RESET = 8'h7D;
   localparam count_type LIMIT_RESET  = 16'd240;

   // Code that follows an escape to stand for the escape or the marker byte.
   localparam byte_type  ESC_CODE_ESCAPE = 8'h01;
   localparam byte_type  ESC_CODE_MARKER = 8'h02;

   typedef struct packed {
      byte_type   out_byte;
      status_type frame_status;
      logic       frame_end;
   } result_type;

endpackage

// File: design/efd_chan_if.sv
// Request and response channel interfaces for the deframer.
interface efd_req_if;
   import efd_pkg::*;
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efd_rsp_if;
   import efd_pkg::*;
   logic       valid;
   logic       ready;
   byte_type   out_byte;
   logic [2:0] frame_status;
   logic       frame_end;

   modport source (output valid, output out_byte, output frame_status, output frame_end,
                   input ready);
   modport sink   (input valid, input out_byte, input frame_status, input frame_end,
                   output ready);
endinterface

// File: design/escape_frame_deframer_xor_check_core.sv
// Top level: byte-stuffed frame deframer with running XOR checksum.
// A result is registered into the response register, or into the skid register while that one is held.
// Throughput: one request per cycle; a response register and a skid register keep
// requests flowing while one result waits, and ready only drops when both are full.
// Reset (synchronous, active high) returns to hunting, clears frame state and output valid flags,
// and restores marker 0x7E, escape 0x7D and a frame limit of 240.
module escape_frame_deframer_xor_check_core (
   input  logic                   clock,
   input  logic                   reset,
   efd_req_if.sink                req,
   efd_rsp_if.source              rsp,
   input  logic                   csr_wr_en,
   input  efd_pkg::csr_index_type csr_index,
   input  efd_pkg::csr_data_type  csr_wdata
);
   import efd_pkg::*;

   byte_type   marker_ff, escape_ff;
   count_type  limit_ff;

   logic       in_frame_ff, in_frame_in;
   logic       esc_pend_ff, esc_pend_in;
   logic       esc_err_ff, esc_err_in;
   logic       held_valid_ff, held_valid_in;
   byte_type   held_byte_ff, held_byte_in;
   byte_type   xor_ff, xor_in;
   count_type  count_ff, count_in;

   logic       out_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff;

   logic       accept, pop, have_res;
   result_type res;
   logic       is_marker;
   count_type  count_inc;
   logic       have_val;
   byte_type   val;
   status_type end_st;

   assign req.ready = !skid_valid_ff;
   assign accept    = req.valid && req.ready;
   assign pop       = out_valid_ff && rsp.ready;

   assign is_marker = (req.rx_byte == marker_ff);
   assign count_inc = count_ff + 16'd1;

   always_comb begin
      in_frame_in   = in_frame_ff;
      esc_pend_in   = esc_pend_ff;
      esc_err_in    = esc_err_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      xor_in        = xor_ff;
      count_in      = count_ff;
      have_res      = 1'b0;
      res           = '{out_byte: 8'd0, frame_status: ST_PAYLOAD, frame_end: 1'b0};
      have_val      = 1'b0;
      val           = 8'd0;
      end_st        = ST_GOOD;

      if (esc_err_ff || esc_pend_ff) begin
         end_st = ST_BADESC;
      end else if (!held_valid_ff || xor_ff != 8'd0) begin
         end_st = ST_BADSUM;
      end

      if (!in_frame_ff) begin
         if (is_marker) begin
            in_frame_in   = 1'b1;
            esc_pend_in   = 1'b0;
            esc_err_in    = 1'b0;
            held_valid_in = 1'b0;
            xor_in        = 8'd0;
            count_in      = 16'd0;
         end
      end else if (is_marker) begin
         // A bad frame's closing marker also opens the next frame.
         have_res      = 1'b1;
         res           = '{out_byte: 8'd0, frame_status: end_st, frame_end: 1'b1};
         in_frame_in   = (end_st != ST_GOOD);
         esc_pend_in   = 1'b0;
         esc_err_in    = 1'b0;
         held_valid_in = 1'b0;
         xor_in        = 8'd0;
         count_in      = 16'd0;
      end else if (count_inc >= limit_ff) begin
         have_res      = 1'b1;
         res           = '{out_byte: 8'd0, frame_status: ST_OVERFLOW, frame_end: 1'b1};
         in_frame_in   = 1'b0;
         esc_pend_in   = 1'b0;
         esc_err_in    = 1'b0;
         held_valid_in = 1'b0;
         xor_in        = 8'd0;
         count_in      = 16'd0;
      end else begin
         count_in = count_inc;
         if (!esc_err_ff) begin
            if (esc_pend_ff) begin
               esc_pend_in = 1'b0;
               if (req.rx_byte == ESC_CODE_ESCAPE) begin
                  val      = escape_ff;
                  have_val = 1'b1;
               end else if (req.rx_byte == ESC_CODE_MARKER) begin
                  val      = marker_ff;
                  have_val = 1'b1;
               end else begin
                  esc_err_in = 1'b1;
               end
            end else if (req.rx_byte == escape_ff) begin
               esc_pend_in = 1'b1;
            end else begin
               val      = req.rx_byte;
               have_val = 1'b1;
            end
         end
         if (have_val) begin
            // The previous byte goes out now; the newest may yet be the checksum.
            have_res      = held_valid_ff;
            res           = '{out_byte: held_byte_ff, frame_status: ST_PAYLOAD,
                              frame_end: 1'b0};
            held_byte_in  = val;
            held_valid_in = 1'b1;
            xor_in        = xor_ff ^ val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff     <= MARKER_RESET;
         escape_ff     <= ESCAPE_RESET;
         limit_ff      <= LIMIT_RESET;
         in_frame_ff   <= 1'b0;
         esc_pend_ff   <= 1'b0;
         esc_err_ff    <= 1'b0;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= 8'd0;
         xor_ff        <= 8'd0;
         count_ff      <= 16'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MARKER: marker_ff <= csr_wdata[7:0];
               CSR_ESCAPE: escape_ff <= csr_wdata[7:0];
               CSR_LIMIT:  limit_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            in_frame_ff   <= in_frame_in;
            esc_pend_ff   <= esc_pend_in;
            esc_err_ff    <= esc_err_in;
            held_valid_ff <= held_valid_in;
            held_byte_ff  <= held_byte_in;
            xor_ff        <= xor_in;
            count_ff      <= count_in;
         end
         if (skid_valid_ff) begin
            if (pop) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (accept && have_res && out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else if (accept && have_res) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept && have_res && out_valid_ff && !pop) begin
         skid_ff <= res;
      end else if (accept && have_res) begin
         out_ff <= res;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.out_byte     = out_ff.out_byte;
   assign rsp.frame_status = out_ff.frame_status;
   assign rsp.frame_end    = out_ff.frame_end;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the response register is empty");

   a_payload_not_end: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.frame_end) |-> (rsp.frame_status == ST_PAYLOAD))
      else $error("payload response carries an end status");

   a_hunt_no_held: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (!held_valid_ff && !esc_pend_ff && !esc_err_ff))
      else $error("frame state left over while hunting");

   a_overflow_leaves_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && have_res && res.frame_status == ST_OVERFLOW) |=> !in_frame_ff)
      else $error("overflow did not return the block to hunting");

endmodule

// File: bench/tb.sv
// Self-checking bench for the byte-stuffed frame deframer with XOR checksum.
`timescale 1ns / 100ps

module tb;
   import efd_pkg::*;

   typedef struct packed {
      logic       typed;
      logic       has_result;
      result_type want;
   } item_note_type;

   typedef struct packed {
      byte_type      rx;
      item_note_type note;
   } directed_row_type;

   typedef struct {
      byte_type  marker;
      byte_type  escape;
      count_type limit;
      int        idle;
      int        stall;
      bit        pressure;
   } phase_type;

   localparam item_note_type PREDICTED  = '0;
   localparam item_note_type QUIET      = '{typed: 1'b1, has_result: 1'b0, want: '0};
   localparam item_note_type END_GOOD   = '{typed: 1'b1, has_result: 1'b1,
      want: '{out_byte: 8'h00, frame_status: ST_GOOD, frame_end: 1'b1}};
   localparam item_note_type END_BADSUM = '{typed: 1'b1, has_result: 1'b1,
      want: '{out_byte: 8'h00, frame_status: ST_BADSUM, frame_end: 1'b1}};
   localparam item_note_type END_BADESC = '{typed: 1'b1, has_result: 1'b1,
      want: '{out_byte: 8'h00, frame_status: ST_BADESC, frame_end: 1'b1}};

   localparam int DIRECTED_ROWS   = 24;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 170;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 4;

   // Reset values of the registers apply throughout this table.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00, QUIET},      '{8'hFF, QUIET},      '{8'h7E, QUIET},      '{8'h7E, END_BADSUM},
      '{8'h55, PREDICTED},  '{8'h7D, PREDICTED},  '{8'h01, PREDICTED},  '{8'h7D, PREDICTED},
      '{8'h02, PREDICTED},  '{8'h56, PREDICTED},  '{8'h7E, END_GOOD},   '{8'h7E, QUIET},
      '{8'h00, PREDICTED},  '{8'h7E, END_GOOD},   '{8'h7E, QUIET},      '{8'hFF, PREDICTED},
      '{8'h7D, PREDICTED},  '{8'h03, PREDICTED},  '{8'hAA, PREDICTED},  '{8'h7E, END_BADESC},
      '{8'h7D, PREDICTED},  '{8'h7E, END_BADESC}, '{8'h12, PREDICTED},  '{8'h7E, END_BADSUM}
   };

   phase_type phases [PHASES] = '{
      '{8'h7E, 8'h7D, 16'd240,   0,  0,  1'b0},
      '{8'h00, 8'hFF, 16'd3,     51, 0,  1'b0},
      '{8'hFF, 8'h00, 16'd65535, 0,  51, 1'b0},
      '{8'h5A, 8'h5A, 16'd20,    17, 17, 1'b0},
      '{8'hC0, 8'hDB, 16'd1000,  0,  0,  1'b1},
      '{8'h7E, 8'h7D, 16'd8,     51, 51, 1'b0}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   efd_req_if req_ch ();
   efd_rsp_if rsp_ch ();

   escape_frame_deframer_xor_check_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow of the block: register copies and per-frame state.
   byte_type  cfg_marker;
   byte_type  cfg_escape;
   count_type cfg_limit;
   logic      frame_open;
   logic      esc_seen;
   logic      esc_fault;
   logic      hold_valid;
   byte_type  hold_byte;
   byte_type  xor_acc;
   count_type raw_bytes;

   result_type    pending_results [$];
   item_note_type item_notes [$];
   int unsigned   error_count    = 0;
   int unsigned   accepted_items = 0;

   // Values the frame builder stuffs against; follow the register writes.
   byte_type link_marker;
   byte_type link_escape;
   int       idle_pct  = 0;
   int       stall_pct = 0;
   logic     hold_go   = 1'b0;
   int       hold_left = HOLD_CYCLES;

   function automatic void clear_frame();
      esc_seen   = 1'b0;
      esc_fault  = 1'b0;
      hold_valid = 1'b0;
      hold_byte  = 8'h00;
      xor_acc    = 8'h00;
      raw_bytes  = 16'd0;
   endfunction

   // Advances the shadow by one received byte; returns 1 when a result is due.
   function automatic logic unstuff_byte(input byte_type b, output result_type r);
      byte_type   val;
      logic       have;
      status_type st;
      r    = '0;
      val  = 8'h00;
      have = 1'b0;
      if (!frame_open) begin
         if (b == cfg_marker) begin
            frame_open = 1'b1;
            clear_frame();
         end
         return 1'b0;
      end
      if (b == cfg_marker) begin
         if (esc_fault || esc_seen) st = ST_BADESC;
         else if (!hold_valid || xor_acc != 8'h00) st = ST_BADSUM;
         else st = ST_GOOD;
         r.frame_status = st;
         r.frame_end    = 1'b1;
         // A bad frame's closing marker doubles as the next opening one.
         if (st == ST_GOOD) frame_open = 1'b0;
         clear_frame();
         return 1'b1;
      end
      raw_bytes = raw_bytes + 16'd1;
      if (raw_bytes >= cfg_limit) begin
         r.frame_status = ST_OVERFLOW;
         r.frame_end    = 1'b1;
         frame_open     = 1'b0;
         clear_frame();
         return 1'b1;
      end
      if (esc_fault) return 1'b0;
      if (esc_seen) begin
         esc_seen = 1'b0;
         if (b == ESC_CODE_ESCAPE) begin
            val  = cfg_escape;
            have = 1'b1;
         end else if (b == ESC_CODE_MARKER) begin
            val  = cfg_marker;
            have = 1'b1;
         end else begin
            esc_fault = 1'b1;
         end
      end else if (b == cfg_escape) begin
         esc_seen = 1'b1;
      end else begin
         val  = b;
         have = 1'b1;
      end
      if (!have) return 1'b0;
      // Each byte is held back one step, so the checksum itself never leaves.
      r.out_byte     = hold_byte;
      r.frame_status = ST_PAYLOAD;
      r.frame_end    = 1'b0;
      have           = hold_valid;
      hold_byte      = val;
      hold_valid     = 1'b1;
      xor_acc        = xor_acc ^ val;
      return have;
   endfunction

   always @(posedge clock) begin : scoreboard
      result_type    want;
      result_type    predicted;
      item_note_type note;
      logic          produced;
      if (reset) begin
         cfg_marker = MARKER_RESET;
         cfg_escape = ESCAPE_RESET;
         cfg_limit  = LIMIT_RESET;
         frame_open = 1'b0;
         clear_frame();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MARKER: cfg_marker = csr_wdata[7:0];
               CSR_ESCAPE: cfg_escape = csr_wdata[7:0];
               CSR_LIMIT:  cfg_limit  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $error("response with none outstanding: out_byte %02h status %0d end %0b",
                      rsp_ch.out_byte, rsp_ch.frame_status, rsp_ch.frame_end);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_ch.out_byte);
                  error_count++;
               end
               if (rsp_ch.frame_status !== 3'(want.frame_status)) begin
                  $error("frame_status: expected %0d, got %0d",
                         want.frame_status, rsp_ch.frame_status);
                  error_count++;
               end
               if (rsp_ch.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_ch.frame_end);
                  error_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            note = item_notes.pop_front();
            accepted_items++;
            produced = unstuff_byte(req_ch.rx_byte, predicted);
            if (note.typed) begin
               produced  = note.has_result;
               predicted = note.want;
            end
            if (produced) pending_results.push_back(predicted);
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_go && hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // Leaves valid high on return, so back-to-back requests need no gap.
   task automatic offer_byte(input byte_type b, input item_note_type note);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      item_notes.push_back(note);
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_frame();
      byte_type payload [$];
      byte_type xsum;
      byte_type b;
      byte_type code;
      int       kind;
      int       len;
      int       cut;
      kind = $urandom_range(99, 0);
      if (kind < 7) begin
         repeat ($urandom_range(6, 1)) offer_byte(byte_type'($urandom), PREDICTED);
         return;
      end
      len  = ($urandom_range(19, 0) == 0) ? $urandom_range(60, 11) : $urandom_range(10, 0);
      xsum = 8'h00;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(5, 0))
            0:       b = link_marker;
            1:       b = link_escape;
            default: b = byte_type'($urandom);
         endcase
         payload.push_back(b);
         xsum ^= b;
      end
      if (kind < 17) xsum ^= byte_type'($urandom_range(255, 1));
      // The lowest of the bad-checksum kinds leaves the checksum out altogether.
      if (kind >= 11) payload.push_back(xsum);
      cut = (kind >= 17 && kind < 25) ? $urandom_range(payload.size(), 0) : -1;
      offer_byte(link_marker, PREDICTED);
      for (int i = 0; i <= payload.size(); i++) begin
         if (i == cut) begin
            do code = byte_type'($urandom);
            while (code == ESC_CODE_ESCAPE || code == ESC_CODE_MARKER);
            offer_byte(link_escape, PREDICTED);
            offer_byte(code, PREDICTED);
         end
         if (i < payload.size()) begin
            if (payload[i] == link_escape) begin
               offer_byte(link_escape, PREDICTED);
               offer_byte(ESC_CODE_ESCAPE, PREDICTED);
            end else if (payload[i] == link_marker) begin
               offer_byte(link_escape, PREDICTED);
               offer_byte(ESC_CODE_MARKER, PREDICTED);
            end else begin
               offer_byte(payload[i], PREDICTED);
            end
         end
      end
      if (kind >= 25 && kind < 30) offer_byte(link_escape, PREDICTED);
      offer_byte(link_marker, PREDICTED);
   endtask

   // Stops the sender and lets every outstanding result and in-flight request drain.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned start_count;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_MARKER;
      csr_wdata      = 16'h0000;
      link_marker    = MARKER_RESET;
      link_escape    = ESCAPE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) offer_byte(directed_rows[i].rx, directed_rows[i].note);

      foreach (phases[p]) begin
         settle();
         idle_pct  = phases[p].idle;
         stall_pct = phases[p].stall;
         csr_wr_en <= 1'b1;
         csr_index <= CSR_MARKER;
         csr_wdata <= {8'h00, phases[p].marker};
         @(posedge clock);
         csr_index <= CSR_ESCAPE;
         csr_wdata <= {8'h00, phases[p].escape};
         @(posedge clock);
         csr_index <= CSR_LIMIT;
         csr_wdata <= phases[p].limit;
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         link_marker = phases[p].marker;
         link_escape = phases[p].escape;
         if (phases[p].pressure) hold_go <= 1'b1;
         start_count = accepted_items;
         while (accepted_items - start_count < ITEMS_PER_PHASE) send_frame();
      end

      settle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
